[hw/rtl/nll_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package nll_pkg;
    localparam int SW       = 24;              // sample width
    localparam int FRAC     = SW - 2;          // fraction bits of a sample
    localparam int ACC_W    = 30;              // pre-saturation accumulator
    localparam int MAG_W    = 30;
    localparam int SQ_W     = 26;
    localparam int A_W      = 28;
    localparam int B_W      = 29;
    localparam int DVD_W    = 52;
    localparam int DIV_STEPS = 24;             // quotient bits
    localparam int CNT_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE    = 3'd4;

    // datapath operations
    localparam logic [3:0] OP_NOP  = 4'd0;
    localparam logic [3:0] OP_LOAD = 4'd1;
    localparam logic [3:0] OP_U1   = 4'd2;
    localparam logic [3:0] OP_U2   = 4'd3;
    localparam logic [3:0] OP_U3   = 4'd4;
    localparam logic [3:0] OP_MAG  = 4'd5;
    localparam logic [3:0] OP_SQ   = 4'd6;
    localparam logic [3:0] OP_AB   = 4'd7;
    localparam logic [3:0] OP_DIV  = 4'd8;
    localparam logic [3:0] OP_SEND = 4'd9;
    localparam logic [3:0] OP_SRC  = 4'd10;
    localparam logic [3:0] OP_ST1  = 4'd11;
    localparam logic [3:0] OP_ST2  = 4'd12;
    localparam logic [3:0] OP_TAP  = 4'd13;

    typedef struct packed {
        logic [3:0] op;
        logic       first;   // first stage of a pass: source is the input saturator
    } t_cmd;

    typedef struct packed {
        logic big;           // saturator input beyond +-3
    } t_stat;
endpackage
`default_nettype wire

[hw/rtl/nll_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module nll_ctrl import nll_pkg::*; #(
    parameter int OVERSAMPLE = 2,
    parameter int NUM_STAGES = 4
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  wire  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    localparam int PW = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
    localparam int KW = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_U1   = 4'd1;
    localparam logic [3:0] S_U2   = 4'd2;
    localparam logic [3:0] S_U3   = 4'd3;
    localparam logic [3:0] S_MAG  = 4'd4;
    localparam logic [3:0] S_SQ   = 4'd5;
    localparam logic [3:0] S_AB   = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_SEND = 4'd8;
    localparam logic [3:0] S_SRC  = 4'd9;
    localparam logic [3:0] S_ST1  = 4'd10;
    localparam logic [3:0] S_ST2  = 4'd11;
    localparam logic [3:0] S_TAP  = 4'd12;

    logic [3:0]       r_state, n_state;
    logic [PW-1:0]    r_pass, n_pass;
    logic [KW-1:0]    r_k, n_k;
    logic             r_phase, n_phase;   // 0: input saturator, 1: stage saturator
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // sequence the passes and stages
    always_comb begin
        n_state     = r_state;
        n_pass      = r_pass;
        n_k         = r_k;
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd.op    = OP_NOP;
        o_cmd.first = (r_k == '0);
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_pass   = '0;
                    n_state  = S_U1;
                end
            end
            S_U1: begin
                o_cmd.op = OP_U1;
                n_state  = S_U2;
            end
            S_U2: begin
                o_cmd.op = OP_U2;
                n_state  = S_U3;
            end
            S_U3: begin
                o_cmd.op = OP_U3;
                n_phase  = 1'b0;
                n_state  = S_MAG;
            end
            S_MAG: begin
                o_cmd.op = OP_MAG;
                n_state  = S_SQ;
            end
            S_SQ: begin
                o_cmd.op = OP_SQ;
                n_state  = i_stat.big ? S_SEND : S_AB;
            end
            S_AB: begin
                o_cmd.op = OP_AB;
                n_cnt    = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_SEND;
                end
            end
            S_SEND: begin
                o_cmd.op = OP_SEND;
                if (!r_phase) begin
                    n_k     = '0;
                    n_phase = 1'b1;
                    n_state = S_SRC;
                end else begin
                    n_state = S_ST1;
                end
            end
            S_SRC: begin
                o_cmd.op = OP_SRC;
                n_state  = S_MAG;
            end
            S_ST1: begin
                o_cmd.op = OP_ST1;
                n_state  = S_ST2;
            end
            S_ST2: begin
                o_cmd.op = OP_ST2;
                if (r_k == KW'(NUM_STAGES - 1)) begin
                    if (r_pass == PW'(OVERSAMPLE - 1)) begin
                        n_state = S_TAP;
                    end else begin
                        n_pass  = r_pass + 1'b1;
                        n_state = S_U1;
                    end
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_SRC;
                end
            end
            S_TAP: begin
                // wait for the output register to free up
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.op    = OP_TAP;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= '0;
            r_k         <= '0;
            r_phase     <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pass      <= n_pass;
            r_k         <= n_k;
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/nll_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module nll_datapath import nll_pkg::*; #(
    parameter int NUM_STAGES = 4
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire signed [SW-1:0]   i_sample_in,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic signed [SW-1:0]  o_sample_out
);
    localparam logic [MAG_W-1:0] SAT_LIM = MAG_W'(3) << FRAC;
    localparam logic [A_W-1:0]   K27     = A_W'(27) << FRAC;
    localparam logic [SW-1:0]    ONE     = SW'(1) << FRAC;

    logic [15:0] r_cutoff;
    logic [18:0] r_fb_gain;
    logic [16:0] r_comp;
    logic [18:0] r_drive;
    logic        r_slope;

    logic signed [SW-1:0]    r_x;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_neg;
    logic                    r_big;
    logic [SW-1:0]           r_mag;
    logic [SQ_W-1:0]         r_sq;
    logic [B_W-1:0]          r_b;
    logic [B_W-1:0]          r_rem;
    logic [SW-1:0]           r_dl;
    logic signed [SW-1:0]    r_t;
    logic signed [SW-1:0]    r_prev;
    logic signed [SW-1:0]    r_stage [NUM_STAGES];
    logic signed [SW-1:0]    r_out;

    // shared gain multiplier: operand times unsigned gain, floor shift by 16
    logic signed [ACC_W-1:0] mul_a;
    logic signed [19:0]      mul_b;
    logic signed [49:0]      mul_p;
    logic signed [33:0]      mul_s;

    logic [MAG_W-1:0]  mag_full;
    logic [47:0]       sq_p;
    logic [A_W-1:0]    a_val;
    logic [B_W-1:0]    b_val;
    logic [DVD_W-1:0]  dvd;
    logic [B_W:0]      trial;
    logic              ge;
    logic [SW-1:0]     q_val;
    logic signed [SW:0]   diff;
    logic signed [ACC_W:0] st_sum;
    logic signed [SW-1:0] st_new;
    logic signed [SW-1:0] src;

    assign src = i_cmd.first ? r_t : r_prev;

    // pick multiplier operands
    always_comb begin
        case (i_cmd.op)
            OP_U1: begin
                mul_a = ACC_W'(r_x);
                mul_b = $signed({1'b0, r_drive});
            end
            OP_U2: begin
                mul_a = r_acc;
                mul_b = $signed({3'b0, r_comp});
            end
            OP_U3: begin
                mul_a = ACC_W'(r_stage[NUM_STAGES-1]);
                mul_b = $signed({1'b0, r_fb_gain});
            end
            OP_SRC: begin
                mul_a = ACC_W'(src);
                mul_b = $signed({1'b0, r_drive});
            end
            OP_ST1: begin
                mul_a = ACC_W'(diff);
                mul_b = $signed({4'b0, r_cutoff});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign mul_s = mul_p[49:16];

    // saturator arithmetic
    assign mag_full = r_acc[ACC_W-1] ? MAG_W'(-r_acc) : MAG_W'(r_acc);
    assign sq_p     = r_mag * r_mag;
    assign a_val    = K27 + A_W'(r_sq);
    assign b_val    = B_W'(K27) + B_W'(r_sq) * B_W'(9);
    assign dvd      = DVD_W'(r_mag) * DVD_W'(a_val);
    assign trial    = {r_rem, r_dl[SW-1]};
    assign ge       = (trial >= {1'b0, r_b});
    assign q_val    = r_big ? ONE : r_dl;

    // stage update
    assign diff   = (SW+1)'(r_t) - (SW+1)'(r_stage[0]);
    assign st_sum = (ACC_W+1)'(r_stage[0]) + (ACC_W+1)'(r_acc);
    always_comb begin
        if (st_sum > $signed((ACC_W+1)'({1'b0, {(SW-1){1'b1}}}))) begin
            st_new = {1'b0, {(SW-1){1'b1}}};
        end else if (st_sum < -$signed((ACC_W+1)'({1'b1, {(SW-1){1'b0}}}))) begin
            st_new = {1'b1, {(SW-1){1'b0}}};
        end else begin
            st_new = st_sum[SW-1:0];
        end
    end

    assign o_stat.big   = r_big;
    assign o_sample_out = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff  <= 16'd32768;
            r_fb_gain <= '0;
            r_comp    <= 17'd65536;
            r_drive   <= 19'd65536;
            r_slope   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CUTOFF:   r_cutoff  <= i_cfg_data[15:0];
                REG_FEEDBACK: r_fb_gain <= i_cfg_data;
                REG_COMP:     r_comp    <= i_cfg_data[16:0];
                REG_DRIVE:    r_drive   <= i_cfg_data;
                REG_SLOPE:    r_slope   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // filter state; stages rotate so the one being updated sits at the head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                r_stage[i] <= '0;
            end
        end else if (i_cmd.op == OP_ST2) begin
            for (int i = 0; i < NUM_STAGES - 1; i++) begin
                r_stage[i] <= r_stage[i+1];
            end
            r_stage[NUM_STAGES-1] <= st_new;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: r_x <= i_sample_in;
            OP_U1, OP_U2, OP_SRC, OP_ST1: r_acc <= mul_s[ACC_W-1:0];
            OP_U3: r_acc <= r_acc - mul_s[ACC_W-1:0];
            OP_MAG: begin
                r_neg <= r_acc[ACC_W-1];
                r_big <= (mag_full > SAT_LIM);
                r_mag <= mag_full[SW-1:0];
            end
            OP_SQ: r_sq <= sq_p[FRAC +: SQ_W];
            OP_AB: begin
                r_b   <= b_val;
                r_rem <= B_W'(dvd[DVD_W-1:SW]);
                r_dl  <= dvd[SW-1:0];
            end
            OP_DIV: begin
                r_rem <= ge ? B_W'(trial - {1'b0, r_b}) : trial[B_W-1:0];
                r_dl  <= {r_dl[SW-2:0], ge};
            end
            OP_SEND: r_t <= r_neg ? -$signed(q_val) : $signed(q_val);
            OP_ST2: r_prev <= st_new;
            OP_TAP: r_out <= r_slope ? r_stage[1] : r_stage[NUM_STAGES-1];
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

[hw/rtl/nonlinear_ladder_lowpass_top.sv]
// Each saturation runs magnitude, square and operand steps, a bit-serial divide and a
// send step. The block takes no new sample until the last result sits in the output
// register; most of each sample's time goes to the shared bit-serial divider.
// Saturations whose input exceeds +-3 skip the divide and finish sooner.
// Reset (synchronous, active low) clears the stages and loads default gains.
`timescale 1ns / 1ps
`default_nettype none
module nonlinear_ladder_lowpass_top import nll_pkg::*; #(
    parameter int OVERSAMPLE = 2,
    parameter int NUM_STAGES = 4
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire signed [SW-1:0]   i_sample_in,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output logic signed [SW-1:0]  o_sample_out
);
    t_cmd  cmd;
    t_stat stat;

    nll_ctrl #(
        .OVERSAMPLE(OVERSAMPLE),
        .NUM_STAGES(NUM_STAGES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    nll_datapath #(
        .NUM_STAGES(NUM_STAGES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_sample_in),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_sample_out (o_sample_out)
    );

    // an accepted beat starts work at once
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block not busy after input beat");

    // a result only appears at the end of a busy period
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result raised without work");

    // hold a stalled result beat unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_sample_out)))
        else $error("stalled result changed");
endmodule
`default_nettype wire
